// ===== design/tma_pkg.sv =====
// Shared types, constants and helpers for the transform matrix accumulate block.
// No dependencies; the top level and the testbench refer to it by scoped names.
package tma_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ELEMS         = 16;
  localparam int IDX_W         = 4;
  localparam int DATA_W        = 32;

  localparam logic signed [DATA_W-1:0] I32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] I32_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    CMD_IDENT = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_MUL   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // element of the identity matrix; row == column on the diagonal
  function automatic logic [DATA_W-1:0] ident_elem(input logic [IDX_W-1:0] idx,
                                                   input logic [DATA_W-1:0] one);
    ident_elem = (idx[3:2] == idx[1:0]) ? one : '0;
  endfunction

endpackage

// ===== design/transform_matrix_accumulate.sv =====
// Transform matrix accumulate: 4x4 signed fixed point transform T and operand P.
// Uses tma_pkg and two tma_ram instances (one for T, one for P).
//
// Usage
//   Input channel (in_valid/in_ready): one word carries a command, an element
//   index and a value. Identity reloads T, write stores the value into P at the
//   index, multiply replaces T by T * P, read leaves everything unchanged.
//   Output channel (out_valid/out_ready): one word per input word, holding T at
//   the index after the command and the saturation flag of the last multiply.
//   Identity, write and read pass through S_RD, where T is read at the index,
//   and S_RESP, where the result is registered; a multiply first runs S_MUL
//   and S_DRAIN. A multiply is 64 steps through one 32x32 multiplier, one
//   product a cycle, with P read from its RAM every step and each row of T
//   read once into a row buffer; the products are shifted, summed, saturated
//   and written back in place row by row. One word is processed at a time:
//   in_ready rises again as the result is registered in the output register,
//   so the next word is not taken before the last one is through.
//   A stalled receiver holds the result in the output register; the next word
//   can still be taken, and its result waits until that register is free.
//   Reset: T and P read as identity (per-entry valid bits), flag cleared.
module transform_matrix_accumulate #(
  parameter int FRACTION_BITS = tma_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [3:0]         in_element_index,
  input  logic signed [31:0] in_element_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_transform_element,
  output logic               out_saturated
);

  localparam int SumW = 64 - FRACTION_BITS + 2;
  localparam logic [31:0] One = 32'd1 << FRACTION_BITS;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DRAIN, S_RD, S_RESP} state_t;

  state_t state_r;
  logic [3:0]  idx_r;
  logic [5:0]  cnt_r;              // {row, column, k}
  logic [15:0] tv_r, pv_r;         // entry written since reset (T: or identity)
  logic        sat_r;

  // read side bookkeeping
  logic [3:0]  t_rd_addr_r, p_rd_addr_r;
  logic        t_vld_r, p_vld_r;

  // multiply pipeline
  logic        s1_v_r, s1_c0_r;
  logic [1:0]  s1_k_r, s2_k_r;
  logic [3:0]  s1_dst_r, s2_dst_r, s3_dst_r;
  logic        s2_v_r, s3_v_r;
  logic signed [31:0] row_r [4];
  logic signed [63:0] prod_r;
  logic signed [SumW-1:0] acc_r, acc_nxt;

  logic        in_acc;
  logic        t_re, p_re, p_we;
  logic [3:0]  t_raddr, p_raddr;
  logic [31:0] t_rdata, p_rdata;
  logic signed [31:0] t_mem_op, t_op, p_op, sat_val;
  logic signed [63:0] sh64;
  logic        sat_hi, sat_lo;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign p_we     = in_acc && (tma_pkg::cmd_t'(in_command) == tma_pkg::CMD_WRITE);

  always_comb begin
    t_re    = 1'b0;
    t_raddr = idx_r;
    if (state_r == S_MUL) begin
      t_re    = (cnt_r[3:2] == 2'd0);
      t_raddr = {cnt_r[5:4], cnt_r[1:0]};
    end else if (state_r == S_RD) begin
      t_re = 1'b1;
    end
  end

  assign p_re    = (state_r == S_MUL);
  assign p_raddr = {cnt_r[1:0], cnt_r[3:2]};

  // never-written entries read as identity
  assign t_mem_op = t_vld_r ? $signed(t_rdata) : $signed(tma_pkg::ident_elem(t_rd_addr_r, One));
  assign p_op     = p_vld_r ? $signed(p_rdata) : $signed(tma_pkg::ident_elem(p_rd_addr_r, One));
  assign t_op     = s1_c0_r ? t_mem_op : row_r[s1_k_r];

  assign sh64    = prod_r >>> FRACTION_BITS;
  assign acc_nxt = ((s2_k_r == 2'd0) ? SumW'(0) : acc_r) + SumW'(sh64);

  assign sat_hi  = acc_r > SumW'(tma_pkg::I32_MAX);
  assign sat_lo  = acc_r < SumW'(tma_pkg::I32_MIN);
  assign sat_val = sat_hi ? tma_pkg::I32_MAX : (sat_lo ? tma_pkg::I32_MIN : 32'(acc_r));

  tma_ram #(.WIDTH(32), .DEPTH(tma_pkg::ELEMS)) u_t_ram (
    .clk   (clk),
    .we    (s3_v_r),
    .waddr (s3_dst_r),
    .wdata (sat_val),
    .re    (t_re),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  tma_ram #(.WIDTH(32), .DEPTH(tma_pkg::ELEMS)) u_p_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (in_element_index),
    .wdata (in_element_value),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  always_ff @(posedge clk) begin
    // payload registers
    if (t_re) begin
      t_rd_addr_r <= t_raddr;
      t_vld_r     <= tv_r[t_raddr];
    end
    if (p_re) begin
      p_rd_addr_r <= p_raddr;
      p_vld_r     <= pv_r[p_raddr];
    end
    s1_c0_r  <= (cnt_r[3:2] == 2'd0);
    s1_k_r   <= cnt_r[1:0];
    s1_dst_r <= cnt_r[5:2];
    if (s1_v_r && s1_c0_r) begin
      row_r[s1_k_r] <= t_mem_op;
    end
    prod_r   <= t_op * p_op;
    s2_k_r   <= s1_k_r;
    s2_dst_r <= s1_dst_r;
    if (s2_v_r) begin
      acc_r <= acc_nxt;
    end
    s3_dst_r <= s2_dst_r;
    if (in_acc) begin
      idx_r <= in_element_index;
    end

    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      tv_r      <= '0;
      pv_r      <= '0;
      sat_r     <= 1'b0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_v_r <= (state_r == S_MUL);
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r && (s2_k_r == 2'd3);
      if (s3_v_r) begin
        tv_r[s3_dst_r] <= 1'b1;
        if (sat_hi || sat_lo) begin
          sat_r <= 1'b1;
        end
      end
      if (p_we) begin
        pv_r[in_element_index] <= 1'b1;
      end
      // S_RESP reloads the output register itself
      if (out_valid && out_ready && state_r != S_RESP) begin
        out_valid <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (tma_pkg::cmd_t'(in_command))
              tma_pkg::CMD_IDENT: begin
                tv_r    <= '0;
                state_r <= S_RD;
              end
              tma_pkg::CMD_WRITE: state_r <= S_RD;
              tma_pkg::CMD_MUL: begin
                sat_r   <= 1'b0;
                cnt_r   <= '0;
                state_r <= S_MUL;
              end
              tma_pkg::CMD_READ: state_r <= S_RD;
            endcase
          end
        end
        S_MUL: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // wait for the last row to be written back
          if (!s1_v_r && !s2_v_r && !s3_v_r) begin
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_RESP;
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_transform_element <= t_mem_op;
            out_saturated         <= sat_r;
            out_valid             <= 1'b1;
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/tma_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module tma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tma_chk.sv =====
// Port-level checks for transform_matrix_accumulate, attached by bind.
// Depends only on the top level's ports.
module tma_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_transform_element,
  input logic               out_saturated
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_transform_element)
                                && $stable(out_saturated))
    else $error("result word changed while stalled");

  // one word in flight: after taking a word the input closes
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice without a result");

  // a new result is only produced while the input is closed
  a_rose_closed: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while input was open");

  // reset empties the output and opens the input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset state wrong");

endmodule

bind transform_matrix_accumulate tma_chk u_tma_chk (.*);

// ===== tb/sv/transform_matrix_accumulate_tb.sv =====
// Self-checking testbench for transform_matrix_accumulate: directed then random command words.
// Depends on tma_pkg and the block itself; a local predictor supplies the expected outputs.
`timescale 1ns / 1ps

module transform_matrix_accumulate_tb;

  localparam int FRAC       = tma_pkg::FRAC_BITS_DEF;
  localparam int RAND_WORDS = 1600;
  localparam int TAIL_WORDS = 120;
  localparam int STALL_MAX  = 4000;
  localparam int DRAIN_CYC  = 120;

  typedef struct {
    tma_pkg::cmd_t      cmd;
    logic [3:0]         idx;
    logic signed [31:0] val;
  } cmd_word_t;

  typedef struct {
    logic signed [31:0] elem;
    logic               sat;
  } elem_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_command = tma_pkg::CMD_READ;
  logic [3:0]         in_element_index = '0;
  logic signed [31:0] in_element_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_transform_element;
  logic               out_saturated;

  cmd_word_t    cmd_words[$];
  elem_result_t expected_elems[$];

  // predictor state
  logic signed [31:0] xf_model [16];
  logic signed [31:0] opnd_model [16];
  logic               clamp_seen;

  logic tail_phase = 1'b0;
  int   error_count = 0;
  int   quiet_cycles = 0;

  transform_matrix_accumulate #(
    .FRACTION_BITS(FRAC)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_command           (in_command),
    .in_element_index     (in_element_index),
    .in_element_value     (in_element_value),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_transform_element(out_transform_element),
    .out_saturated        (out_saturated)
  );

  always #5 clk = ~clk;

  function automatic logic signed [31:0] unit_elem(int i);
    return ((i % 5) == 0) ? (32'sd1 <<< FRAC) : 32'sd0;
  endfunction

  function automatic void multiply_model();
    logic signed [31:0] nxt [16];
    longint acc;
    longint prod;
    clamp_seen = 1'b0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          prod = longint'(xf_model[r*4+k]) * longint'(opnd_model[k*4+c]);
          acc += prod >>> FRAC;  // floor
        end
        if (acc > longint'(tma_pkg::I32_MAX)) begin
          acc = longint'(tma_pkg::I32_MAX);
          clamp_seen = 1'b1;
        end else if (acc < longint'(tma_pkg::I32_MIN)) begin
          acc = longint'(tma_pkg::I32_MIN);
          clamp_seen = 1'b1;
        end
        nxt[r*4+c] = acc[31:0];
      end
    end
    for (int i = 0; i < 16; i++) xf_model[i] = nxt[i];
  endfunction

  function automatic void predict_word(logic [1:0] cmd, logic [3:0] idx,
                                       logic signed [31:0] val);
    elem_result_t res;
    case (tma_pkg::cmd_t'(cmd))
      tma_pkg::CMD_IDENT: for (int i = 0; i < 16; i++) xf_model[i] = unit_elem(i);
      tma_pkg::CMD_WRITE: opnd_model[idx] = val;
      tma_pkg::CMD_MUL:   multiply_model();
      default:   ;
    endcase
    res.elem = xf_model[idx];
    res.sat  = clamp_seen;
    expected_elems.push_back(res);
  endfunction

  function automatic void queue_word(tma_pkg::cmd_t cmd, int idx, logic signed [31:0] val);
    cmd_word_t w;
    w.cmd = cmd;
    w.idx = idx[3:0];
    w.val = val;
    cmd_words.push_back(w);
  endfunction

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $signed($urandom_range(0, 32'h0002_0000));
      4:          v = 32'sh0001_0000 + $signed($urandom_range(0, 32'h3FFF)) - 32'sh2000;
      5, 6:       v = $signed($urandom);
      7: begin
        case ($urandom_range(0, 3))
          0:       v = tma_pkg::I32_MAX;
          1:       v = tma_pkg::I32_MIN;
          2:       v = -32'sd1;
          default: v = 32'sd0;
        endcase
      end
      8:          v = $signed($urandom_range(0, 255));
      default:    v = 32'sd0;
    endcase
    if ($urandom_range(0, 1) == 1 && v != tma_pkg::I32_MIN) v = -v;
    return v;
  endfunction

  function automatic void build_random_words();
    int n;
    while (cmd_words.size() < RAND_WORDS + 20) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // load operand, accumulate, look at the transform
          if ($urandom_range(0, 1) == 1)
            queue_word(tma_pkg::CMD_IDENT, $urandom_range(0, 15), $urandom);
          if ($urandom_range(0, 2) == 0) begin
            for (int i = 0; i < 16; i++) queue_word(tma_pkg::CMD_WRITE, i, pick_value());
          end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
              queue_word(tma_pkg::CMD_WRITE, $urandom_range(0, 15), pick_value());
          end
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++)
            queue_word(tma_pkg::CMD_MUL, $urandom_range(0, 15), $urandom);
          n = $urandom_range(0, 3);
          for (int i = 0; i < n; i++)
            queue_word(tma_pkg::CMD_READ, $urandom_range(0, 15), $urandom);
        end
        6, 7: begin
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++)
            queue_word(tma_pkg::cmd_t'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom);
        end
        8: begin
          // repeated multiplies drive the transform towards saturation
          n = $urandom_range(4, 8);
          for (int i = 0; i < n; i++)
            queue_word(tma_pkg::CMD_MUL, $urandom_range(0, 15), $urandom);
          queue_word(tma_pkg::CMD_READ, $urandom_range(0, 15), $urandom);
        end
        default: begin
          queue_word(tma_pkg::CMD_IDENT, $urandom_range(0, 15), $urandom);
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++)
            queue_word(tma_pkg::CMD_READ, $urandom_range(0, 15), $urandom);
        end
      endcase
    end
  endfunction

  // sender
  always @(posedge clk) begin : drive_words
    int        gap_left;
    int        calm_left;
    bit        fire;
    cmd_word_t w;
    fire = in_valid && in_ready;
    if (fire) predict_word(in_command, in_element_index, in_element_value);
    tail_phase <= (cmd_words.size() < TAIL_WORDS);
    if (rst_n && (fire || !in_valid)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_words.size() > 0) begin
        w = cmd_words.pop_front();
        in_valid         <= 1'b1;
        in_command       <= w.cmd;
        in_element_index <= w.idx;
        in_element_value <= w.val;
        if (calm_left > 0) begin
          calm_left--;
        end else if (cmd_words.size() >= TAIL_WORDS) begin
          case ($urandom_range(0, 9))
            0, 1, 2: gap_left = $urandom_range(1, 6);
            3:       calm_left = $urandom_range(20, 60);
            default: ;
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin : drive_ready
    int hold_left;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (tail_phase) begin
      out_ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          out_ready <= 1'b0;
          hold_left = $urandom_range(1, 6) - 1;
        end
        3: begin
          out_ready <= 1'b1;
          hold_left = $urandom_range(20, 80);
        end
        default: begin
          out_ready <= 1'b1;
          hold_left = $urandom_range(0, 5);
        end
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    elem_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_elems.size() == 0) begin
        $error("unexpected result word: transform_element %h saturated %b",
               out_transform_element, out_saturated);
        error_count++;
      end else begin
        e = expected_elems.pop_front();
        if (out_transform_element !== e.elem) begin
          $error("transform_element: expected %h, actual %h", e.elem, out_transform_element);
          error_count++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated: expected %b, actual %b", e.sat, out_saturated);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) begin
      xf_model[i]   = unit_elem(i);
      opnd_model[i] = unit_elem(i);
    end
    clamp_seen = 1'b0;

    // identity after reset
    queue_word(tma_pkg::CMD_READ, 0, 32'sd0);
    queue_word(tma_pkg::CMD_READ, 15, -32'sd1);
    queue_word(tma_pkg::CMD_READ, 1, tma_pkg::I32_MAX);
    queue_word(tma_pkg::CMD_MUL, 5, tma_pkg::I32_MIN);
    // operand writes show the untouched transform
    queue_word(tma_pkg::CMD_WRITE, 0, tma_pkg::I32_MAX);
    queue_word(tma_pkg::CMD_WRITE, 15, tma_pkg::I32_MIN);
    queue_word(tma_pkg::CMD_WRITE, 5, -32'sd1);
    queue_word(tma_pkg::CMD_WRITE, 10, 32'sd0);
    queue_word(tma_pkg::CMD_MUL, 0, 32'sd0);      // T becomes P, no clamp
    queue_word(tma_pkg::CMD_MUL, 0, 32'sd0);      // positive clamp
    queue_word(tma_pkg::CMD_READ, 15, 32'sd0);
    queue_word(tma_pkg::CMD_IDENT, 15, tma_pkg::I32_MAX);  // flag survives identity
    queue_word(tma_pkg::CMD_READ, 0, 32'sd0);
    queue_word(tma_pkg::CMD_MUL, 10, 32'sd0);     // flag cleared again
    queue_word(tma_pkg::CMD_MUL, 5, 32'sd0);      // negative operands, floor rounding
    queue_word(tma_pkg::CMD_WRITE, 0, tma_pkg::I32_MIN);
    queue_word(tma_pkg::CMD_IDENT, 3, 32'sd0);
    queue_word(tma_pkg::CMD_MUL, 0, 32'sd0);
    queue_word(tma_pkg::CMD_WRITE, 0, tma_pkg::I32_MAX);
    queue_word(tma_pkg::CMD_MUL, 0, 32'sd0);      // negative clamp
    queue_word(tma_pkg::CMD_WRITE, 3, 32'sh0000_8000);
    queue_word(tma_pkg::CMD_READ, 3, 32'sd0);
    build_random_words();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (cmd_words.size() != 0 || in_valid || expected_elems.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);

    if (error_count == 0 && expected_elems.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
